FILE: rtl/rgbhsl_pkg.sv
// ----------------------------------------------------------------------------
// rgbhsl_pkg
// Shared types for the RGB to HSL pixel pipeline.
// ----------------------------------------------------------------------------
package rgbhsl_pkg;

    // Sector selected by the largest channel.
    typedef enum logic [1:0] {
        SEC_RED   = 2'd0,
        SEC_GREEN = 2'd1,
        SEC_BLUE  = 2'd2
    } t_sector;

endpackage

FILE: rtl/rgbhsl_div.sv
// ----------------------------------------------------------------------------
// rgbhsl_div
// Pipelined restoring divider, one quotient bit per stage, with stall.
// ----------------------------------------------------------------------------
module rgbhsl_div #(
    parameter int NUM_BITS = 24,
    parameter int DEN_BITS = 11,
    parameter int TAG_BITS = 8
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_adv,
    input  logic                i_valid,
    input  logic [NUM_BITS-1:0] i_num,
    input  logic [DEN_BITS-1:0] i_den,
    input  logic [TAG_BITS-1:0] i_tag,
    output logic                o_valid,
    output logic [NUM_BITS-1:0] o_quo,
    output logic [TAG_BITS-1:0] o_tag
);

    localparam int RB = DEN_BITS + 1;

    logic [NUM_BITS:0]     r_vld;
    logic [NUM_BITS-1:0]   r_num [NUM_BITS+1];
    logic [RB-1:0]         r_rem [NUM_BITS+1];
    logic [DEN_BITS-1:0]   r_den [NUM_BITS+1];
    logic [TAG_BITS-1:0]   r_tag [NUM_BITS+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_adv) begin
            r_vld <= {r_vld[NUM_BITS-1:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_num[0] <= i_num;
            r_rem[0] <= '0;
            r_den[0] <= i_den;
            r_tag[0] <= i_tag;
        end
    end

    // Each stage shifts in the next dividend bit and subtracts if it fits.
    for (genvar k = 0; k < NUM_BITS; k++) begin : g_stage
        logic [RB:0]   w_trial;
        logic [RB-1:0] w_sh;
        assign w_sh    = {r_rem[k][RB-2:0], r_num[k][NUM_BITS-1]};
        assign w_trial = {1'b0, w_sh} - {2'b00, r_den[k]};
        always_ff @(posedge i_clk) begin
            if (i_adv) begin
                r_den[k+1] <= r_den[k];
                r_tag[k+1] <= r_tag[k];
                r_num[k+1] <= {r_num[k][NUM_BITS-2:0], ~w_trial[RB]};
                r_rem[k+1] <= w_trial[RB] ? w_sh : w_trial[RB-1:0];
            end
        end
    end

    assign o_valid = r_vld[NUM_BITS];
    assign o_quo   = r_num[NUM_BITS];
    assign o_tag   = r_tag[NUM_BITS];

endmodule

FILE: rtl/rgbhsl_front.sv
// ----------------------------------------------------------------------------
// rgbhsl_front
// Two register stages: max, min and sector, then dividends and divisors.
// ----------------------------------------------------------------------------
module rgbhsl_front
    import rgbhsl_pkg::*;
#(
    parameter int CHANNEL_BITS  = 8,
    parameter int FRACTION_BITS = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_adv,
    input  logic                                 i_valid,
    input  logic [CHANNEL_BITS-1:0]              i_red,
    input  logic [CHANNEL_BITS-1:0]              i_green,
    input  logic [CHANNEL_BITS-1:0]              i_blue,
    output logic                                 o_valid,
    output logic [CHANNEL_BITS+FRACTION_BITS+2:0] o_hnum,
    output logic [CHANNEL_BITS+2:0]              o_hden,
    output logic [CHANNEL_BITS+FRACTION_BITS-1:0] o_snum,
    output logic [CHANNEL_BITS:0]                o_sden,
    output logic                                 o_hzero,
    output logic                                 o_szero,
    output logic [CHANNEL_BITS:0]                o_sum
);

    localparam int CB = CHANNEL_BITS;
    localparam int FB = FRACTION_BITS;
    localparam logic [CB:0] FULL2 = {1'b1, {CB{1'b1}}} - 1'b1;

    logic          r_v1;
    logic [CB-1:0] r_r, r_g, r_b, r_mx, r_mn;
    t_sector       r_sec;
    logic [CB-1:0] n_mx, n_mn;
    t_sector       n_sec;

    always_comb begin
        n_mx = i_red;
        n_sec = SEC_RED;
        if (i_green > n_mx) begin
            n_mx = i_green;
            n_sec = SEC_GREEN;
        end
        if (i_blue > n_mx) begin
            n_mx = i_blue;
            n_sec = SEC_BLUE;
        end
        n_mn = i_red;
        if (i_green < n_mn) n_mn = i_green;
        if (i_blue < n_mn) n_mn = i_blue;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            o_valid <= 1'b0;
        end else if (i_adv) begin
            r_v1 <= i_valid;
            o_valid <= r_v1;
        end
    end

    logic [CB-1:0] w_c;
    logic [CB:0]   w_sum, w_inv;
    logic [CB+2:0] w_hn;
    assign w_c   = r_mx - r_mn;
    assign w_sum = {1'b0, r_mx} + {1'b0, r_mn};
    assign w_inv = FULL2 - w_sum;

    always_comb begin
        case (r_sec)
            SEC_RED: begin
                if (r_g >= r_b) w_hn = {3'b000, r_g - r_b};
                else w_hn = ({3'b000, w_c} * 3'd6) - {3'b000, r_b - r_g};
            end
            SEC_GREEN: w_hn = {2'b00, w_c, 1'b0} + {3'b000, r_b} - {3'b000, r_r};
            SEC_BLUE:  w_hn = {1'b0, w_c, 2'b00} + {3'b000, r_r} - {3'b000, r_g};
            default:   w_hn = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_r <= i_red;
            r_g <= i_green;
            r_b <= i_blue;
            r_mx <= n_mx;
            r_mn <= n_mn;
            r_sec <= n_sec;
            o_hnum <= {w_hn, {FB{1'b0}}};
            o_hden <= {3'b000, w_c} * 3'd6;
            // c * (2^FB - 1) as a shift and subtract.
            o_snum <= {w_c, {FB{1'b0}}} - {{FB{1'b0}}, w_c};
            o_sden <= (w_sum < w_inv) ? w_sum : w_inv;
            o_hzero <= (w_c == '0);
            o_szero <= (w_sum == '0) || (w_sum == FULL2);
            o_sum <= w_sum;
        end
    end

endmodule

FILE: rtl/rgb_to_hsl_pixel.sv
// ----------------------------------------------------------------------------
// rgb_to_hsl_pixel
// RGB to HSL conversion of one pixel per clock in a stallable pipeline.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake          Payload
// pixel     in         i_valid / o_ready  i_red, i_green, i_blue
// result    out        o_valid / i_ready  o_hue, o_saturation, o_lightness_x2
//
// One pixel enters every cycle while the output is not held. The longer
// hue divider sets the total delay; the two bit-per-stage dividers for hue
// and saturation run side by side behind two front stages of max/min and
// setup. Reset clears only the valid bits of the stages. When the output
// is held the whole pipeline freezes; ready is high whenever the output
// register is empty or being drained, so nothing is dropped or repeated.
// ----------------------------------------------------------------------------
module rgb_to_hsl_pixel
    import rgbhsl_pkg::*;
#(
    parameter int CHANNEL_BITS  = 8,
    parameter int FRACTION_BITS = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic [CHANNEL_BITS-1:0]  i_red,
    input  logic [CHANNEL_BITS-1:0]  i_green,
    input  logic [CHANNEL_BITS-1:0]  i_blue,
    output logic                     o_valid,
    input  logic                     i_ready,
    output logic [FRACTION_BITS-1:0] o_hue,
    output logic [FRACTION_BITS-1:0] o_saturation,
    output logic [CHANNEL_BITS:0]    o_lightness_x2
);

    localparam int CB = CHANNEL_BITS;
    localparam int FB = FRACTION_BITS;
    localparam int HN = CB + FB + 3;
    localparam int SN = CB + FB;
    // The hue divider, being longer, sets the total delay; the saturation
    // path is padded to match with a short delay line on its result.
    localparam int PAD = HN - SN;
    localparam int TB  = CB + 3;

    logic w_adv;
    // The pipeline moves when the last stage is empty or being taken.
    assign w_adv   = !o_valid || i_ready;
    assign o_ready = w_adv;

    logic          w_fv, w_hz, w_sz;
    logic [HN-1:0] w_hnum;
    logic [CB+2:0] w_hden;
    logic [SN-1:0] w_snum;
    logic [CB:0]   w_sden, w_sum;

    rgbhsl_front #(.CHANNEL_BITS(CB), .FRACTION_BITS(FB)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_adv(w_adv), .i_valid(i_valid),
        .i_red(i_red), .i_green(i_green), .i_blue(i_blue),
        .o_valid(w_fv), .o_hnum(w_hnum), .o_hden(w_hden),
        .o_snum(w_snum), .o_sden(w_sden), .o_hzero(w_hz), .o_szero(w_sz),
        .o_sum(w_sum)
    );

    logic          w_hv;
    logic [HN-1:0] w_hq;
    logic [TB-1:0] w_htag;

    // The tag carries the grey and black/white flags and the lightness alongside.
    rgbhsl_div #(.NUM_BITS(HN), .DEN_BITS(CB + 3), .TAG_BITS(TB)) u_hdiv (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_adv(w_adv), .i_valid(w_fv),
        .i_num(w_hnum), .i_den(w_hden), .i_tag({w_hz, w_sz, w_sum}),
        .o_valid(w_hv), .o_quo(w_hq), .o_tag(w_htag)
    );

    logic          w_sv;
    logic [SN-1:0] w_sq;
    logic          w_stag;

    rgbhsl_div #(.NUM_BITS(SN), .DEN_BITS(CB + 1), .TAG_BITS(1)) u_sdiv (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_adv(w_adv), .i_valid(w_fv),
        .i_num(w_snum), .i_den(w_sden), .i_tag(1'b0),
        .o_valid(w_sv), .o_quo(w_sq), .o_tag(w_stag)
    );

    // The saturation quotient travels with its own valid and tag bits so
    // that all three line up with the hue result at the output.
    logic [FB+1:0] w_sin;
    logic [FB+1:0] r_spad [PAD];
    assign w_sin = {w_sv, w_stag, w_sq[FB-1:0]};
    for (genvar k = 0; k < PAD; k++) begin : g_pad
        if (k == 0) begin : g_first
            always_ff @(posedge i_clk) begin
                if (w_adv) r_spad[k] <= w_sin;
            end
        end else begin : g_next
            always_ff @(posedge i_clk) begin
                if (w_adv) r_spad[k] <= r_spad[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (w_adv) begin
            o_valid <= w_hv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            o_hue <= w_htag[TB-1] ? '0 : w_hq[FB-1:0];
            o_saturation <= (w_htag[TB-2] || r_spad[PAD-1][FB] || !r_spad[PAD-1][FB+1])
                            ? '0 : r_spad[PAD-1][FB-1:0];
            o_lightness_x2 <= w_htag[CB:0];
        end
    end

endmodule

FILE: dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for rgb_to_hsl_pixel: pixels go in with random gaps,
// results come out with random stalls, and each result is compared field by
// field against a local model of the conversion.
// ----------------------------------------------------------------------------
module tb;
    import rgbhsl_pkg::*;

    localparam int CB = 8;
    localparam int FB = 16;
    localparam int FULL = (1 << CB) - 1;
    localparam int LATENCY = FB + CB + 7;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam logic [CB-1:0] PIX_MAX = '1;
    localparam logic [CB-1:0] PIX_MAX_M1 = PIX_MAX - 1'b1;

    typedef struct packed {
        logic [FB-1:0] hue;
        logic [FB-1:0] sat;
        logic [CB:0]   light;
    } t_hsl;

    logic          i_clk;
    logic          i_rst_n;
    logic          i_valid;
    logic          o_ready;
    logic [CB-1:0] i_red;
    logic [CB-1:0] i_green;
    logic [CB-1:0] i_blue;
    logic          o_valid;
    logic          i_ready;
    logic [FB-1:0] o_hue;
    logic [FB-1:0] o_saturation;
    logic [CB:0]   o_lightness_x2;

    t_hsl hsl_expected[$];
    int   error_count = 0;
    int   idle_cycles = 0;
    bit   stall_enable;

    rgb_to_hsl_pixel #(.CHANNEL_BITS(CB), .FRACTION_BITS(FB)) u_dut (.*);

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Conversion model: sector by largest channel, red then green then blue.
    function automatic t_hsl convert_pixel(logic [CB-1:0] r, logic [CB-1:0] g,
                                           logic [CB-1:0] b);
        longint  mx;
        longint  mn;
        longint  c;
        longint  sum;
        longint  num;
        longint  den;
        t_sector sector;
        t_hsl    res;
        mx = r;
        mn = r;
        if (g > mx) mx = g;
        if (b > mx) mx = b;
        if (g < mn) mn = g;
        if (b < mn) mn = b;
        c = mx - mn;
        sum = mx + mn;
        res = '0;
        if (c != 0) begin
            sector = (mx == r) ? SEC_RED : (mx == g) ? SEC_GREEN : SEC_BLUE;
            case (sector)
                SEC_RED: begin
                    // A negative red-sector hue wraps by one full turn.
                    num = (g >= b) ? (g - b) : (6 * c - (b - g));
                end
                SEC_GREEN: begin
                    num = 2 * c + b - r;
                end
                default: begin
                    num = 4 * c + r - g;
                end
            endcase
            res.hue = FB'((num << FB) / (6 * c));
        end
        // Black and white carry no saturation.
        if (sum != 0 && sum < 2 * FULL) begin
            den = (sum < 2 * FULL - sum) ? sum : (2 * FULL - sum);
            res.sat = FB'((c * ((1 << FB) - 1)) / den);
        end
        res.light = (CB + 1)'(sum);
        return res;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        error_count++;
    endtask

    // Mostly short gaps, now and then a long one.
    function automatic int gap_length();
        if ($urandom_range(0, 3) == 0) return 0;
        if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
        return $urandom_range(0, 3);
    endfunction

    // Sends one pixel; valid holds until the transfer happens. Valid is left
    // high afterwards and is lowered by a gap or by an idle period.
    task automatic send_pixel(logic [CB-1:0] r, logic [CB-1:0] g, logic [CB-1:0] b,
                              bit with_gap);
        int gap;
        gap = with_gap ? gap_length() : 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_red <= r;
        i_green <= g;
        i_blue <= b;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        hsl_expected.push_back(convert_pixel(r, g, b));
        @(negedge i_clk);
    endtask

    // Result side stalls at random; bursts with no stalls happen too.
    initial begin
        int hold;
        i_ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (!stall_enable || $urandom_range(0, 1) == 0) begin
                i_ready <= 1'b1;
            end else begin
                hold = gap_length() + 1;
                i_ready <= 1'b0;
                repeat (hold) @(negedge i_clk);
                i_ready <= 1'b1;
            end
        end
    end

    // Result checker, sampled at the rising edge.
    always @(posedge i_clk) begin
        t_hsl want;
        if (i_rst_n && o_valid && i_ready) begin
            if (hsl_expected.size() == 0) begin
                report_mismatch("unexpected result", 0, 0);
            end else begin
                want = hsl_expected.pop_front();
                if (o_hue !== want.hue) report_mismatch("hue", o_hue, want.hue);
                if (o_saturation !== want.sat)
                    report_mismatch("saturation", o_saturation, want.sat);
                if (o_lightness_x2 !== want.light)
                    report_mismatch("lightness_x2", o_lightness_x2, want.light);
            end
        end
    end

    // Watchdog over cycles with no transfer on either side.
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("rgb_to_hsl_pixel regression: fail");
            $finish;
        end
    end

    // Stops sending and waits until every expected result has come.
    task automatic wait_drained();
        i_valid <= 1'b0;
        while (hsl_expected.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_extremes();
        logic [CB-1:0] v[4] = '{'0, CB'(1), PIX_MAX_M1, PIX_MAX};
        send_pixel('0, '0, '0, 1'b0);
        send_pixel(PIX_MAX, PIX_MAX, PIX_MAX, 1'b0);
        send_pixel(8'd128, 8'd128, 8'd128, 1'b0);          // grey
        send_pixel(PIX_MAX, '0, '0, 1'b0);
        send_pixel('0, PIX_MAX, '0, 1'b0);
        send_pixel('0, '0, PIX_MAX, 1'b0);
        send_pixel(PIX_MAX, '0, 8'd1, 1'b0);               // red sector wraps
        send_pixel(8'd200, 8'd10, 8'd150, 1'b0);           // red sector wraps
        send_pixel(PIX_MAX, PIX_MAX, '0, 1'b0);            // red beats green
        send_pixel('0, PIX_MAX, PIX_MAX, 1'b0);            // green beats blue
        send_pixel(PIX_MAX, '0, PIX_MAX, 1'b0);            // red beats blue
        send_pixel(8'd1, '0, '0, 1'b0);
        send_pixel(PIX_MAX, PIX_MAX_M1, PIX_MAX, 1'b0);
        send_pixel(8'hAA, 8'h55, 8'h0F, 1'b0);
        send_pixel(8'h55, 8'hAA, 8'hF0, 1'b0);
        for (int k = 0; k < 4; k++) send_pixel(v[k], v[3 - k], v[(k + 1) % 4], 1'b0);
    endtask

    task automatic test_random(int count);
        logic [CB-1:0] r;
        logic [CB-1:0] g;
        logic [CB-1:0] b;
        for (int k = 0; k < count; k++) begin
            r = CB'($urandom);
            g = CB'($urandom);
            b = CB'($urandom);
            // Some pixels near grey, black or white for the small divisors.
            if ($urandom_range(0, 4) == 0) begin
                g = r + CB'($urandom_range(0, 2));
                b = r - CB'($urandom_range(0, 2));
            end
            send_pixel(r, g, b, 1'b1);
            if (k == count / 2) wait_drained();
        end
    endtask

    task automatic test_back_to_back(int count);
        stall_enable = 0;
        for (int k = 0; k < count; k++)
            send_pixel(CB'($urandom), CB'($urandom), CB'($urandom), 1'b0);
        stall_enable = 1;
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_red = '0;
        i_green = '0;
        i_blue = '0;
        stall_enable = 1;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_extremes();
        test_random(1300);
        test_back_to_back(230);
        wait_drained();
        repeat (LATENCY + 5) @(posedge i_clk);
        if (error_count == 0) begin
            $display("rgb_to_hsl_pixel regression: pass");
        end else begin
            $display("rgb_to_hsl_pixel regression: fail");
        end
        $finish;
    end

endmodule
